/* hw/rtl/stb_pkg.sv */
// package for the timer slot bank: item structs, function codes, default sizes
// used by software_timer_bank_core and the bench; depends on nothing
`default_nettype none

package stb_pkg;

    localparam int SLOTS_DEF       = 16;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int MAX_RESULTS     = 16;
    localparam int RES_CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_START = 2'd1;
    localparam logic [1:0] FUNC_STOP  = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [3:0]  slot;
        logic [15:0] count;
        logic [15:0] reload;
    } t_in_item;

    typedef struct packed {
        logic [3:0] fired_slot;
        logic       last;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } t_state;

endpackage

`default_nettype wire

/* hw/rtl/stb_ram.sv */
// generic simple dual-port ram: one write port, one read port, registered read
// no package dependencies
`default_nettype none

module stb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* hw/rtl/software_timer_bank_core.sv */
// top level of the timer slot bank: command port, slot walk, result strobe
// depends on stb_pkg and stb_ram
`default_nettype none

// A start or stop command is taken while idle; busy stays low and the next command
// can follow at once. A tick walks all SLOTS slots through the slot ram, one
// slot per cycle on its single read port, and holds busy until the walk is done.
// Fired slots come out on o_strobe/o_result in ascending slot order, one per
// cycle at most, each held back until the next fire or the walk ends; the
// result flagged last appears in the cycle busy drops. The receiver cannot stall:
// every strobe is a transfer. At most MAX_RESULTS fires are reported per tick;
// further slots still fire and reload. The active map is cleared by reset, the
// count and reload storage is not.
module software_timer_bank_core
    import stb_pkg::*;
#(
    parameter int SLOTS       = SLOTS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire t_in_item i_item,
    output logic          o_strobe,
    output t_out_item     o_result
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int DW = 2 * COUNT_WIDTH;

    t_state                 r_state, n_state;
    logic [CW-1:0]          r_rd_idx, n_rd_idx;
    logic                   r_pv, n_pv;
    logic [IW-1:0]          r_pidx, n_pidx;
    logic [SLOTS-1:0]       r_active, n_active;
    logic [RES_CNT_W-1:0]   r_n, n_n;
    logic                   r_pend_v, n_pend_v;
    logic [3:0]             r_pend_slot, n_pend_slot;
    logic                   r_out_v, n_out_v;
    t_out_item              r_out, n_out;

    logic                   accept;
    logic                   slot_ok;
    logic [6:0]             slot_ext;
    logic [6:0]             pidx_ext;
    logic [31:0]            count_ext;
    logic [31:0]            reload_ext;
    logic                   we;
    logic [IW-1:0]          waddr;
    logic [DW-1:0]          wdata;
    logic [DW-1:0]          rdata;
    logic [COUNT_WIDTH-1:0] q_cnt;
    logic [COUNT_WIDTH-1:0] q_rel;
    logic                   live;
    logic                   fire;

    assign accept     = start && !busy;
    assign slot_ext   = 7'(i_item.slot);
    assign slot_ok    = slot_ext < 7'(SLOTS);
    assign pidx_ext   = 7'(r_pidx);
    assign count_ext  = 32'(i_item.count);
    assign reload_ext = 32'(i_item.reload);
    assign q_cnt      = rdata[COUNT_WIDTH-1:0];
    assign q_rel      = rdata[DW-1:COUNT_WIDTH];
    assign live       = r_pv && r_active[r_pidx];
    assign fire       = live && (q_cnt <= COUNT_WIDTH'(1));

    stb_ram #(
        .WIDTH (DW),
        .DEPTH (SLOTS),
        .AW    (IW)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_rd_idx[IW-1:0]),
        .o_rdata (rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_rd_idx    = r_rd_idx;
        n_pv        = 1'b0;
        n_pidx      = r_pidx;
        n_active    = r_active;
        n_n         = r_n;
        n_pend_v    = r_pend_v;
        n_pend_slot = r_pend_slot;
        n_out_v     = 1'b0;
        n_out       = r_out;
        we          = 1'b0;
        waddr       = slot_ext[IW-1:0];
        wdata       = {reload_ext[COUNT_WIDTH-1:0], count_ext[COUNT_WIDTH-1:0]};

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_item.func)
                        FUNC_TICK: begin
                            n_state  = ST_WALK;
                            n_rd_idx = '0;
                            n_n      = '0;
                            n_pend_v = 1'b0;
                        end
                        FUNC_START: begin
                            if (slot_ok) begin
                                we                          = 1'b1;
                                n_active[slot_ext[IW-1:0]] = 1'b1;
                            end
                        end
                        FUNC_STOP: begin
                            if (slot_ok) begin
                                n_active[slot_ext[IW-1:0]] = 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_WALK: begin
                // issue the read for the next slot while the previous one is updated
                if (r_rd_idx != CW'(SLOTS)) begin
                    n_pv     = 1'b1;
                    n_pidx   = r_rd_idx[IW-1:0];
                    n_rd_idx = r_rd_idx + CW'(1);
                end

                waddr = r_pidx;
                if (live) begin
                    if (!fire) begin
                        we    = 1'b1;
                        wdata = {q_rel, q_cnt - COUNT_WIDTH'(1)};
                    end else if (q_rel == '0) begin
                        n_active[r_pidx] = 1'b0;
                    end else begin
                        we    = 1'b1;
                        wdata = {q_rel, q_rel};
                    end
                end

                // hold one fire back until we know whether another follows
                if (fire && (r_n < RES_CNT_W'(MAX_RESULTS))) begin
                    if (r_pend_v) begin
                        n_out_v = 1'b1;
                        n_out   = '{fired_slot: r_pend_slot, last: 1'b0};
                    end
                    n_pend_v    = 1'b1;
                    n_pend_slot = pidx_ext[3:0];
                    n_n         = r_n + RES_CNT_W'(1);
                end

                if ((r_rd_idx == CW'(SLOTS)) && !r_pv) begin
                    if (r_pend_v) begin
                        n_out_v = 1'b1;
                        n_out   = '{fired_slot: r_pend_slot, last: 1'b1};
                    end
                    n_pend_v = 1'b0;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pv     <= 1'b0;
            r_active <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pv     <= n_pv;
            r_active <= n_active;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx    <= n_rd_idx;
        r_pidx      <= n_pidx;
        r_n         <= n_n;
        r_pend_slot <= n_pend_slot;
        r_out       <= n_out;
    end

    assign busy     = (r_state == ST_WALK);
    assign o_strobe = r_out_v;
    assign o_result = r_out;

endmodule

`default_nettype wire

/* bench/software_timer_bank_core_test.sv */
// self-checking bench for software_timer_bank_core: directed table, then random commands
// checks every fired-slot transfer against a cycle-free bank model or typed rows; needs stb_pkg
`timescale 1ns / 100ps

module software_timer_bank_core_test;
    import stb_pkg::*;

    localparam int          NSLOT       = SLOTS_DEF;
    localparam logic [1:0]  FUNC_UNUSED = 2'd3;
    localparam int          STALL_LIMIT = 2000;
    localparam int          SETTLE      = NSLOT + 4;

    typedef struct {
        t_in_item         item;
        bit               typed;
        logic [NSLOT-1:0] fires;
    } t_row;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start   = 1'b0;
    t_in_item          i_item  = '0;
    logic              busy;
    logic              o_strobe;
    t_out_item         o_result;

    // tags travel with the command so the checker knows which rows carry typed results
    bit                row_typed = 1'b0;
    logic [NSLOT-1:0]  row_mask  = '0;

    bit                arm_map    [NSLOT];
    logic [15:0]       down_cnt   [NSLOT];
    logic [15:0]       reload_cnt [NSLOT];
    t_out_item         fire_q [$];

    int                mismatches  = 0;
    int                stall_count = 0;
    int                idle_pct    = 0;
    t_row              plan [$];

    software_timer_bank_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_in_item make_cmd(logic [1:0] func, logic [3:0] slot,
                                          logic [15:0] count, logic [15:0] reload);
        t_in_item it;
        it.func   = func;
        it.slot   = slot;
        it.count  = count;
        it.reload = reload;
        return it;
    endfunction

    function automatic t_row make_row(logic [1:0] func, logic [3:0] slot, logic [15:0] count,
                                      logic [15:0] reload, bit typed, logic [NSLOT-1:0] fires);
        t_row r;
        r.item  = make_cmd(func, slot, count, reload);
        r.typed = typed;
        r.fires = fires;
        return r;
    endfunction

    function automatic void log_error(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at %0t: %s", $realtime, msg);
    endfunction

    // updates the slot bank and queues the fired slots of a tick
    function automatic void run_command(t_in_item it, bit typed, logic [NSLOT-1:0] typed_fires);
        logic [NSLOT-1:0] fired;
        t_out_item        res;
        fired = '0;
        case (it.func)
            FUNC_START: begin
                arm_map[it.slot]    = 1'b1;
                down_cnt[it.slot]   = it.count;
                reload_cnt[it.slot] = it.reload;
            end
            FUNC_STOP: begin
                arm_map[it.slot] = 1'b0;
            end
            FUNC_TICK: begin
                for (int s = 0; s < NSLOT; s++) begin
                    if (arm_map[s]) begin
                        if (down_cnt[s] != 16'd0)
                            down_cnt[s] = down_cnt[s] - 16'd1;
                        if (down_cnt[s] == 16'd0) begin
                            fired[s] = 1'b1;
                            if (reload_cnt[s] == 16'd0)
                                arm_map[s] = 1'b0;
                            else
                                down_cnt[s] = reload_cnt[s];
                        end
                    end
                end
            end
            default: ;
        endcase
        if (typed)
            fired = typed_fires;
        for (int s = 0; s < NSLOT; s++) begin
            if (fired[s]) begin
                res.fired_slot = s[3:0];
                res.last       = ((fired >> (s + 1)) == '0);
                fire_q.push_back(res);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (start && !busy)
                run_command(i_item, row_typed, row_mask);
            if (o_strobe) begin
                if (fire_q.size() == 0) begin
                    log_error($sformatf("unexpected transfer slot %0d last %0b",
                                        o_result.fired_slot, o_result.last));
                end else begin
                    want = fire_q.pop_front();
                    if (o_result.fired_slot !== want.fired_slot)
                        log_error($sformatf("fired_slot expected %0d got %0d",
                                            want.fired_slot, o_result.fired_slot));
                    if (o_result.last !== want.last)
                        log_error($sformatf("last expected %0b got %0b (slot %0d)",
                                            want.last, o_result.last, want.fired_slot));
                end
            end
        end
    end

    // watchdog: no command and no result for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe)
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic issue(t_in_item it, bit typed, logic [NSLOT-1:0] fires);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start     <= 1'b1;
        i_item    <= it;
        row_typed <= typed;
        row_mask  <= fires;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
    endtask

    // hold off until every queued fire has been seen
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        wait (fire_q.size() == 0);
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_count(int zero_pct);
        int sel;
        sel = $urandom_range(99);
        if (sel < zero_pct)
            return 16'd0;
        if (sel < 80)
            return 16'($urandom_range(4, 1));
        return 16'($urandom_range(65535));
    endfunction

    task automatic random_phase(int n_items);
        int done;
        int sel;
        done = 0;
        while (done < n_items) begin
            sel = $urandom_range(99);
            if (sel < 5) begin
                issue(make_cmd(FUNC_UNUSED, 4'($urandom_range(15)), 16'($urandom_range(65535)),
                               16'($urandom_range(65535))), 1'b0, '0);
            end else if (sel < 10) begin
                // arm every slot close to zero, then tick for a crowded walk
                for (int s = 0; s < NSLOT; s++)
                    issue(make_cmd(FUNC_START, 4'(s), 16'($urandom_range(1)),
                                   16'($urandom_range(2))), 1'b0, '0);
                issue(make_cmd(FUNC_TICK, 4'($urandom_range(15)), 16'($urandom_range(65535)),
                               16'($urandom_range(65535))), 1'b0, '0);
                done += NSLOT + 1;
            end else if (sel < 50) begin
                issue(make_cmd(FUNC_TICK, 4'($urandom_range(15)), 16'($urandom_range(65535)),
                               16'($urandom_range(65535))), 1'b0, '0);
                done++;
            end else if (sel < 83) begin
                issue(make_cmd(FUNC_START, 4'($urandom_range(15)), pick_count(20),
                               pick_count(35)), 1'b0, '0);
                done++;
            end else begin
                issue(make_cmd(FUNC_STOP, 4'($urandom_range(15)), 16'($urandom_range(65535)),
                               16'($urandom_range(65535))), 1'b0, '0);
                done++;
            end
        end
    endtask

    initial begin
        plan.push_back(make_row(FUNC_TICK,   4'd0,  16'h0000, 16'h0000, 1'b1, 16'h0000));
        plan.push_back(make_row(FUNC_STOP,   4'd5,  16'h0000, 16'h0000, 1'b1, 16'h0000));
        plan.push_back(make_row(FUNC_UNUSED, 4'd15, 16'hFFFF, 16'hFFFF, 1'b1, 16'h0000));
        plan.push_back(make_row(FUNC_START,  4'd0,  16'h0000, 16'h0000, 1'b1, 16'h0000));
        plan.push_back(make_row(FUNC_TICK,   4'd0,  16'h0000, 16'h0000, 1'b1, 16'h0001));
        plan.push_back(make_row(FUNC_TICK,   4'd0,  16'h0000, 16'h0000, 1'b1, 16'h0000));
        plan.push_back(make_row(FUNC_START,  4'd15, 16'h0001, 16'hFFFF, 1'b1, 16'h0000));
        plan.push_back(make_row(FUNC_TICK,   4'd0,  16'h0000, 16'h0000, 1'b1, 16'h8000));
        // restart of a running slot overwrites both counts
        plan.push_back(make_row(FUNC_START,  4'd15, 16'h0002, 16'h0000, 1'b1, 16'h0000));
        plan.push_back(make_row(FUNC_TICK,   4'd0,  16'h0000, 16'h0000, 1'b1, 16'h0000));
        plan.push_back(make_row(FUNC_TICK,   4'd0,  16'h0000, 16'h0000, 1'b1, 16'h8000));
        plan.push_back(make_row(FUNC_START,  4'd3,  16'hFFFF, 16'hFFFF, 1'b1, 16'h0000));
        plan.push_back(make_row(FUNC_STOP,   4'd3,  16'h0000, 16'h0000, 1'b1, 16'h0000));
        plan.push_back(make_row(FUNC_TICK,   4'd0,  16'h0000, 16'h0000, 1'b1, 16'h0000));
        plan.push_back(make_row(FUNC_START,  4'd7,  16'h0003, 16'h0002, 1'b0, 16'h0000));
        plan.push_back(make_row(FUNC_START,  4'd8,  16'h0001, 16'h0001, 1'b0, 16'h0000));
        plan.push_back(make_row(FUNC_START,  4'd10, 16'h0000, 16'hFFFF, 1'b0, 16'h0000));
        plan.push_back(make_row(FUNC_TICK,   4'd0,  16'h0000, 16'h0000, 1'b0, 16'h0000));
        plan.push_back(make_row(FUNC_TICK,   4'd9,  16'hFFFF, 16'hFFFF, 1'b0, 16'h0000));
        plan.push_back(make_row(FUNC_TICK,   4'd0,  16'h0000, 16'h0000, 1'b0, 16'h0000));
        plan.push_back(make_row(FUNC_STOP,   4'd7,  16'h0000, 16'h0000, 1'b0, 16'h0000));
        plan.push_back(make_row(FUNC_STOP,   4'd8,  16'h0000, 16'h0000, 1'b0, 16'h0000));
        plan.push_back(make_row(FUNC_START,  4'd9,  16'hFFFF, 16'h0001, 1'b0, 16'h0000));
        plan.push_back(make_row(FUNC_TICK,   4'd0,  16'h0000, 16'h0000, 1'b0, 16'h0000));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_pct = 23;
        foreach (plan[k])
            issue(plan[k].item, plan[k].typed, plan[k].fires);
        drain();
        random_phase(70);
        drain();

        idle_pct = 78;
        random_phase(70);
        drain();

        idle_pct = 0;
        random_phase(60);
        drain();
        repeat (SETTLE) @(posedge i_clk);

        if (mismatches == 0 && fire_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/stb_pkg.sv
hw/rtl/stb_ram.sv
hw/rtl/software_timer_bank_core.sv
bench/software_timer_bank_core_test.sv
